// ----- sv/tpwm_pkg.sv -----
// ----------------------------------------------------------------------------
// tpwm_pkg
// Shared types, codes and reset values for the three-phase pwm fault gate.
// ----------------------------------------------------------------------------
package tpwm_pkg;

  localparam int COMPARE_WIDTH_DEF  = 16;
  localparam int DUTY_FRAC_BITS_DEF = 16;

  localparam int CMD_W     = 3;
  localparam int CFG_IDX_W = 2;

  localparam int PERIOD_RESET   = 2124;
  localparam int DUTY_MIN_RESET = 0;
  localparam int DUTY_MAX_RESET = 62259;

  typedef enum logic [CMD_W-1:0] {
    CMD_SET_DUTY    = 3'd0,
    CMD_ENABLE      = 3'd1,
    CMD_DISABLE     = 3'd2,
    CMD_CLEAR_FAULT = 3'd3,
    CMD_UPDATE_TICK = 3'd4
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PERIOD   = 2'd0,
    REG_DUTY_MIN = 2'd1,
    REG_DUTY_MAX = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic load_compare;
    logic stage_off;
    logic set_enable;
    logic set_fault;
    logic clear_fault;
    logic hook;
  } ctrl_t;

endpackage

// ----- sv/tpwm_cfg.sv -----
// ----------------------------------------------------------------------------
// tpwm_cfg
// Configuration registers: period, lowest and highest duty.
// ----------------------------------------------------------------------------
module tpwm_cfg #(
  parameter int COMPARE_WIDTH  = tpwm_pkg::COMPARE_WIDTH_DEF,
  parameter int DUTY_FRAC_BITS = tpwm_pkg::DUTY_FRAC_BITS_DEF,
  parameter int CFG_W          = (COMPARE_WIDTH > DUTY_FRAC_BITS + 1) ?
                                 COMPARE_WIDTH : DUTY_FRAC_BITS + 1
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tpwm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]                  cfg_data,
  output logic [COMPARE_WIDTH-1:0]          period,
  output logic [DUTY_FRAC_BITS:0]           duty_min,
  output logic [DUTY_FRAC_BITS:0]           duty_max
);
  import tpwm_pkg::*;

  localparam int DW = DUTY_FRAC_BITS + 1;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      period   <= COMPARE_WIDTH'(PERIOD_RESET);
      duty_min <= DW'(DUTY_MIN_RESET);
      duty_max <= DW'(DUTY_MAX_RESET);
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_PERIOD:   period   <= cfg_data[COMPARE_WIDTH-1:0];
        REG_DUTY_MIN: duty_min <= cfg_data[DW-1:0];
        REG_DUTY_MAX: duty_max <= cfg_data[DW-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- sv/tpwm_decode.sv -----
// ----------------------------------------------------------------------------
// tpwm_decode
// Turns a command and the fault pin into state update controls.
// ----------------------------------------------------------------------------
module tpwm_decode (
  input  logic [tpwm_pkg::CMD_W-1:0] command,
  input  logic                       fault_asserted,
  output tpwm_pkg::ctrl_t            ctrl
);
  import tpwm_pkg::*;

  always_comb begin
    ctrl = '0;
    case (cmd_t'(command))
      CMD_SET_DUTY: ctrl.load_compare = 1'b1;
      CMD_ENABLE: begin
        if (fault_asserted) begin
          ctrl.set_fault = 1'b1;
          ctrl.stage_off = 1'b1;
        end else begin
          ctrl.set_enable = 1'b1;
        end
      end
      CMD_DISABLE: ctrl.stage_off = 1'b1;
      CMD_CLEAR_FAULT: ctrl.clear_fault = 1'b1;
      CMD_UPDATE_TICK: begin
        if (fault_asserted) begin
          ctrl.set_fault = 1'b1;
          ctrl.stage_off = 1'b1;
        end else begin
          ctrl.hook = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- sv/tpwm_scale.sv -----
// ----------------------------------------------------------------------------
// tpwm_scale
// Clamps one duty and scales it by the period into a saturated compare value.
// ----------------------------------------------------------------------------
module tpwm_scale #(
  parameter int COMPARE_WIDTH  = tpwm_pkg::COMPARE_WIDTH_DEF,
  parameter int DUTY_FRAC_BITS = tpwm_pkg::DUTY_FRAC_BITS_DEF
) (
  input  logic [DUTY_FRAC_BITS:0]  duty,
  input  logic [COMPARE_WIDTH-1:0] period,
  input  logic [DUTY_FRAC_BITS:0]  duty_min,
  input  logic [DUTY_FRAC_BITS:0]  duty_max,
  output logic [COMPARE_WIDTH-1:0] compare
);
  import tpwm_pkg::*;

  localparam int DW = DUTY_FRAC_BITS + 1;
  localparam int PW = DW + COMPARE_WIDTH;

  logic [DW-1:0]          duty_lo;
  logic [DW-1:0]          duty_clamped;
  logic [PW-1:0]          product;
  logic [COMPARE_WIDTH:0] scaled;

  // raise to min first, then lower to max
  assign duty_lo      = (duty < duty_min) ? duty_min : duty;
  assign duty_clamped = (duty_lo > duty_max) ? duty_max : duty_lo;
  assign product      = PW'(duty_clamped) * PW'(period);
  assign scaled       = product[PW-1:DUTY_FRAC_BITS];
  assign compare      = scaled[COMPARE_WIDTH] ? '1 : scaled[COMPARE_WIDTH-1:0];

endmodule

// ----- sv/three_phase_pwm_fault_gate.sv -----
// ----------------------------------------------------------------------------
// three_phase_pwm_fault_gate
// Compare and gate control for a three-phase pwm stage with a sticky fault.
//
//   channel  handshake               word
//   in       in_valid / in_stall     command, duty_a/b/c, fault_asserted
//   out      out_valid / out_stall   compare_a/b/c, outputs_enabled,
//                                    fault_latched, run_loop_hook
//   cfg      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// an accepted word passes the input register, then the result register; one
// word per cycle sustained while out_stall is low; the clamp, period multiply
// and saturation sit between the input register and the result register.
// reset loads the default period and duty limits and clears compares,
// enable and fault latch. out_stall holds the result register and backs
// up into in_stall once the input register is also full.
// ----------------------------------------------------------------------------
module three_phase_pwm_fault_gate #(
  parameter int COMPARE_WIDTH  = tpwm_pkg::COMPARE_WIDTH_DEF,
  parameter int DUTY_FRAC_BITS = tpwm_pkg::DUTY_FRAC_BITS_DEF,
  parameter int CFG_W          = (COMPARE_WIDTH > DUTY_FRAC_BITS + 1) ?
                                 COMPARE_WIDTH : DUTY_FRAC_BITS + 1
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [tpwm_pkg::CMD_W-1:0]     command,
  input  logic [DUTY_FRAC_BITS:0]        duty_a,
  input  logic [DUTY_FRAC_BITS:0]        duty_b,
  input  logic [DUTY_FRAC_BITS:0]        duty_c,
  input  logic                           fault_asserted,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [COMPARE_WIDTH-1:0]       compare_a,
  output logic [COMPARE_WIDTH-1:0]       compare_b,
  output logic [COMPARE_WIDTH-1:0]       compare_c,
  output logic                           outputs_enabled,
  output logic                           fault_latched,
  output logic                           run_loop_hook,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tpwm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]               cfg_data
);
  import tpwm_pkg::*;

  logic [COMPARE_WIDTH-1:0]  period;
  logic [DUTY_FRAC_BITS:0]   duty_min;
  logic [DUTY_FRAC_BITS:0]   duty_max;

  logic                      s1_valid;
  logic [CMD_W-1:0]          s1_command;
  logic [DUTY_FRAC_BITS:0]   s1_duty_a;
  logic [DUTY_FRAC_BITS:0]   s1_duty_b;
  logic [DUTY_FRAC_BITS:0]   s1_duty_c;
  logic                      s1_fault;

  ctrl_t                     ctrl;
  logic [COMPARE_WIDTH-1:0]  scaled_a;
  logic [COMPARE_WIDTH-1:0]  scaled_b;
  logic [COMPARE_WIDTH-1:0]  scaled_c;

  logic                      advance;
  logic                      load_out;
  logic                      in_take;

  tpwm_cfg #(
    .COMPARE_WIDTH  (COMPARE_WIDTH),
    .DUTY_FRAC_BITS (DUTY_FRAC_BITS),
    .CFG_W          (CFG_W)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .period    (period),
    .duty_min  (duty_min),
    .duty_max  (duty_max)
  );

  assign advance  = !out_valid || !out_stall;
  assign load_out = s1_valid && advance;
  assign in_stall = s1_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_command <= command;
      s1_duty_a  <= duty_a;
      s1_duty_b  <= duty_b;
      s1_duty_c  <= duty_c;
      s1_fault   <= fault_asserted;
    end
  end

  tpwm_decode u_decode (
    .command        (s1_command),
    .fault_asserted (s1_fault),
    .ctrl           (ctrl)
  );

  tpwm_scale #(
    .COMPARE_WIDTH  (COMPARE_WIDTH),
    .DUTY_FRAC_BITS (DUTY_FRAC_BITS)
  ) u_scale_a (
    .duty     (s1_duty_a),
    .period   (period),
    .duty_min (duty_min),
    .duty_max (duty_max),
    .compare  (scaled_a)
  );

  tpwm_scale #(
    .COMPARE_WIDTH  (COMPARE_WIDTH),
    .DUTY_FRAC_BITS (DUTY_FRAC_BITS)
  ) u_scale_b (
    .duty     (s1_duty_b),
    .period   (period),
    .duty_min (duty_min),
    .duty_max (duty_max),
    .compare  (scaled_b)
  );

  tpwm_scale #(
    .COMPARE_WIDTH  (COMPARE_WIDTH),
    .DUTY_FRAC_BITS (DUTY_FRAC_BITS)
  ) u_scale_c (
    .duty     (s1_duty_c),
    .period   (period),
    .duty_min (duty_min),
    .duty_max (duty_max),
    .compare  (scaled_c)
  );

  // result register, also the stage state
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid       <= 1'b0;
      compare_a       <= '0;
      compare_b       <= '0;
      compare_c       <= '0;
      outputs_enabled <= 1'b0;
      fault_latched   <= 1'b0;
      run_loop_hook   <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
      if (ctrl.load_compare) begin
        compare_a <= scaled_a;
        compare_b <= scaled_b;
        compare_c <= scaled_c;
      end else if (ctrl.stage_off) begin
        compare_a <= '0;
        compare_b <= '0;
        compare_c <= '0;
      end
      if (ctrl.stage_off) begin
        outputs_enabled <= 1'b0;
      end else if (ctrl.set_enable) begin
        outputs_enabled <= 1'b1;
      end
      if (ctrl.set_fault) begin
        fault_latched <= 1'b1;
      end else if (ctrl.clear_fault) begin
        fault_latched <= 1'b0;
      end
      run_loop_hook <= ctrl.hook;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  a_stall_needs_word : assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid)
    else $error("input stalled with empty input register");

  a_stage_off_clears : assert property (@(posedge clk) disable iff (rst)
    (load_out && ctrl.stage_off) |=>
      (compare_a == '0 && compare_b == '0 && compare_c == '0 && !outputs_enabled))
    else $error("stage not switched off");

  a_fault_tick_latches : assert property (@(posedge clk) disable iff (rst)
    (load_out && cmd_t'(s1_command) == CMD_UPDATE_TICK && s1_fault) |=>
      (fault_latched && !run_loop_hook && out_valid))
    else $error("fault on update tick not latched");

  a_hook_keeps_fault : assert property (@(posedge clk) disable iff (rst)
    (load_out && ctrl.hook) |=> (fault_latched == $past(fault_latched)))
    else $error("loop hook word changed the fault latch");

endmodule
